// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define VTGD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define VTGD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: src/vtgd_pkg.sv
// ----------------------------------------------------------------------------
// vtgd_pkg
// Types and constants of the vector tile geometry decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package vtgd_pkg;

    localparam int WORD_W  = 32;
    localparam int COUNT_W = 29;
    localparam int POINT_W = 48;
    localparam int CFG_INDEX_W = 1;

    localparam logic [2:0] CMD_ID_MOVE  = 3'd1;
    localparam logic [2:0] CMD_ID_LINE  = 3'd2;
    localparam logic [2:0] CMD_ID_CLOSE = 3'd7;

    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_X = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_Y = 1'b1;

    localparam logic [WORD_W-1:0] SCALE_RESET = 32'h0001_0000;

    typedef enum logic [1:0] {
        KIND_MOVE  = 2'd0,
        KIND_LINE  = 2'd1,
        KIND_CLOSE = 2'd2,
        KIND_TRUNC = 2'd3
    } kind_t;

    typedef struct packed {
        logic                     valid;
        kind_t                    kind;
        logic signed [WORD_W-1:0] cursor_x;
        logic signed [WORD_W-1:0] cursor_y;
    } dec_result_t;

    function automatic logic [WORD_W-1:0] unzigzag(input logic [WORD_W-1:0] w);
        return (w >> 1) ^ {WORD_W{w[0]}};
    endfunction

endpackage

`default_nettype wire

// File: src/vtgd_if.sv
// ----------------------------------------------------------------------------
// vtgd_if
// Valid/ready channels: geometry word items, point items, config writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface vtgd_word_if;
    logic                          valid;
    logic                          ready;
    logic [vtgd_pkg::WORD_W-1:0]   geometry_word;
    logic                          last_word;

    modport source (output valid, output geometry_word, output last_word, input ready);
    modport sink   (input valid, input geometry_word, input last_word, output ready);
endinterface

interface vtgd_point_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          point_kind;
    logic signed [vtgd_pkg::POINT_W-1:0] point_x;
    logic signed [vtgd_pkg::POINT_W-1:0] point_y;

    modport source (output valid, output point_kind, output point_x, output point_y,
                    input ready);
    modport sink   (input valid, input point_kind, input point_x, input point_y,
                    output ready);
endinterface

interface vtgd_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [vtgd_pkg::CFG_INDEX_W-1:0] index;
    logic [vtgd_pkg::WORD_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: src/vtgd_decoder.sv
// ----------------------------------------------------------------------------
// vtgd_decoder
// Command/parameter decode and cursor update, one word per accepted item.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module vtgd_decoder (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic [vtgd_pkg::WORD_W-1:0] word,
    input  wire logic                        last,
    output vtgd_pkg::dec_result_t            res
);

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_MOVE = 2'd1,
        CMD_LINE = 2'd2
    } cmd_t;

    cmd_t                                    cmd_reg, cmd_next;
    logic [vtgd_pkg::COUNT_W-1:0]            pairs_reg, pairs_next;
    logic [vtgd_pkg::WORD_W-1:0]             held_reg, held_next;
    logic                                    await_reg, await_next;
    logic signed [vtgd_pkg::WORD_W-1:0]      cursor_x_reg, cursor_x_next;
    logic signed [vtgd_pkg::WORD_W-1:0]      cursor_y_reg, cursor_y_next;

    logic [2:0]                              cmd_id;
    logic [vtgd_pkg::COUNT_W-1:0]            count;

    assign cmd_id = word[2:0];
    assign count  = word[vtgd_pkg::WORD_W-1:3];

    always_comb
    begin
        cmd_next      = cmd_reg;
        pairs_next    = pairs_reg;
        held_next     = held_reg;
        await_next    = await_reg;
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        res.valid     = 1'b0;
        res.kind      = vtgd_pkg::KIND_MOVE;

        if (pairs_reg == '0)
        begin
            if ((cmd_id == vtgd_pkg::CMD_ID_MOVE || cmd_id == vtgd_pkg::CMD_ID_LINE)
                && count != '0)
            begin
                cmd_next   = (cmd_id == vtgd_pkg::CMD_ID_MOVE) ? CMD_MOVE : CMD_LINE;
                pairs_next = count;
                await_next = 1'b0;
            end
            else if (cmd_id == vtgd_pkg::CMD_ID_CLOSE)
            begin
                res.valid = 1'b1;
                res.kind  = vtgd_pkg::KIND_CLOSE;
            end
        end
        else if (!await_reg)
        begin
            held_next  = word;
            await_next = 1'b1;
        end
        else
        begin
            cursor_x_next = cursor_x_reg + signed'(vtgd_pkg::unzigzag(held_reg));
            cursor_y_next = cursor_y_reg + signed'(vtgd_pkg::unzigzag(word));
            await_next    = 1'b0;
            held_next     = '0;
            res.valid     = 1'b1;
            res.kind      = (cmd_reg == CMD_MOVE) ? vtgd_pkg::KIND_MOVE : vtgd_pkg::KIND_LINE;
            pairs_next    = pairs_reg - 1'b1;
            if (pairs_next == '0)
            begin
                cmd_next = CMD_NONE;
            end
        end

        // emitted point carries the cursor after this word's update
        res.cursor_x = cursor_x_next;
        res.cursor_y = cursor_y_next;

        if (last)
        begin
            if (pairs_next != '0 || await_next)
            begin
                res.valid = 1'b1;
                res.kind  = vtgd_pkg::KIND_TRUNC;
            end
            cmd_next      = CMD_NONE;
            pairs_next    = '0;
            held_next     = '0;
            await_next    = 1'b0;
            cursor_x_next = '0;
            cursor_y_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg      <= CMD_NONE;
            pairs_reg    <= '0;
            held_reg     <= '0;
            await_reg    <= 1'b0;
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
        end
        else if (accept)
        begin
            cmd_reg      <= cmd_next;
            pairs_reg    <= pairs_next;
            held_reg     <= held_next;
            await_reg    <= await_next;
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
        end
    end

    `VTGD_ASSERT_NXT(a_last_clears, accept && last,
        pairs_reg == '0 && !await_reg && cursor_x_reg == '0 && cursor_y_reg == '0)
    `VTGD_ASSERT_IMP(a_await_has_pairs, await_reg, pairs_reg != '0)

endmodule

`default_nettype wire

// File: src/vtgd_scaler.sv
// ----------------------------------------------------------------------------
// vtgd_scaler
// One axis: cursor times Q scale, then realign to 16 fraction bits and
// saturate to 48 bits. Two register stages (product, result).
// ----------------------------------------------------------------------------
`default_nettype none

module vtgd_scaler #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                               clk,
    input  wire logic                               load_prod,
    input  wire logic                               load_res,
    input  wire logic signed [vtgd_pkg::WORD_W-1:0] cursor,
    input  wire logic [vtgd_pkg::WORD_W-1:0]        scale,
    output logic signed [vtgd_pkg::POINT_W-1:0]     result
);

    localparam int UP   = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int DOWN = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
    localparam logic [63:0] POS_LIMIT = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [63:0] NEG_LIMIT = 64'h0000_8000_0000_0000;
    localparam logic [63:0] RND_MASK  = (64'd1 << DOWN) - 64'd1;

    logic [vtgd_pkg::WORD_W-1:0]            mag;
    logic [63:0]                            prod_reg, prod_next;
    logic                                   neg_reg;
    logic [63:0]                            limit;
    logic [63:0]                            q_dn;
    logic [63:0]                            q_sat;
    logic signed [vtgd_pkg::POINT_W-1:0]    res_reg, res_next;

    assign mag       = cursor[vtgd_pkg::WORD_W-1] ? (~cursor + 1'b1) : cursor;
    assign prod_next = {32'd0, mag} * {32'd0, scale};

    always_comb
    begin
        limit = neg_reg ? NEG_LIMIT : POS_LIMIT;
        // negative values round toward minus infinity: ceiling of magnitude
        q_dn  = (prod_reg >> DOWN)
              + (((prod_reg & RND_MASK) + (neg_reg ? RND_MASK : 64'd0)) >> DOWN);
        q_sat = (q_dn > (limit >> UP)) ? limit : (q_dn << UP);
        res_next = neg_reg ? signed'(48'd0 - q_sat[vtgd_pkg::POINT_W-1:0])
                           : signed'(q_sat[vtgd_pkg::POINT_W-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (load_prod)
        begin
            prod_reg <= prod_next;
            neg_reg  <= cursor[vtgd_pkg::WORD_W-1];
        end
        if (load_res)
        begin
            res_reg <= res_next;
        end
    end

    assign result = res_reg;

endmodule

`default_nettype wire

// File: src/vector_tile_geometry_decoder_unit.sv
// ----------------------------------------------------------------------------
// vector_tile_geometry_decoder_unit
// Decodes vector tile geometry words into scaled move/line/close/trunc points.
// ----------------------------------------------------------------------------
// Usage:
//   items  : valid/ready sink, one geometry_word (+ last_word) per item.
//   points : valid/ready source, zero or one point item per geometry word.
//   cfg    : valid/ready write port, index 0 scale_x, index 1 scale_y
//            (unsigned Q with SCALE_FRACTION_BITS fraction bits). Always ready;
//            write only while no items are in flight.
//   Throughput: one item per cycle while items.ready is high. A point
//   appears on points once its word has passed decode/cursor add, multiply
//   and realign/saturate, each ending in a register.
//   Words that only load a command or an x delta produce no point.
//   Stall: a point held on points stalls only its own stage; upstream stages
//   keep filling, and items.ready drops once all three stages hold items.
//   Reset: cursor and command state cleared, scales to 1.0 at 16 fraction bits,
//   pipeline empty. A word flagged last_word clears cursor and command state.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module vector_tile_geometry_decoder_unit #(
    parameter int SCALE_FRACTION_BITS = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    vtgd_word_if.sink   items,
    vtgd_point_if.source points,
    vtgd_cfg_if.sink    cfg
);

    logic [vtgd_pkg::WORD_W-1:0]         scale_x_reg, scale_y_reg;

    vtgd_pkg::dec_result_t               dec_res;
    logic                                accept;
    logic                                adv1, adv2, adv_o;

    logic                                s1_v_reg, s2_v_reg, o_v_reg;
    vtgd_pkg::kind_t                     s1_kind_reg, s2_kind_reg, o_kind_reg;
    logic signed [vtgd_pkg::WORD_W-1:0]  s1_cx_reg, s1_cy_reg;
    logic signed [vtgd_pkg::POINT_W-1:0] px, py;

    assign adv_o  = !o_v_reg || points.ready;
    assign adv2   = !s2_v_reg || adv_o;
    assign adv1   = !s1_v_reg || adv2;
    assign accept = items.valid && adv1;

    assign items.ready = adv1;
    assign cfg.ready   = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_x_reg <= vtgd_pkg::SCALE_RESET;
            scale_y_reg <= vtgd_pkg::SCALE_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                vtgd_pkg::CFG_SCALE_X: scale_x_reg <= cfg.data;
                vtgd_pkg::CFG_SCALE_Y: scale_y_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    vtgd_decoder u_decoder (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .word   (items.geometry_word),
        .last   (items.last_word),
        .res    (dec_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            o_v_reg  <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_v_reg <= accept && dec_res.valid;
            end
            if (adv2)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (adv_o)
            begin
                o_v_reg <= s2_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_kind_reg <= dec_res.kind;
            s1_cx_reg   <= dec_res.cursor_x;
            s1_cy_reg   <= dec_res.cursor_y;
        end
        if (adv2)
        begin
            s2_kind_reg <= s1_kind_reg;
        end
        if (adv_o)
        begin
            o_kind_reg <= s2_kind_reg;
        end
    end

    vtgd_scaler #(
        .FRAC_BITS (SCALE_FRACTION_BITS)
    ) u_scale_x (
        .clk       (clk),
        .load_prod (adv2),
        .load_res  (adv_o),
        .cursor    (s1_cx_reg),
        .scale     (scale_x_reg),
        .result    (px)
    );

    vtgd_scaler #(
        .FRAC_BITS (SCALE_FRACTION_BITS)
    ) u_scale_y (
        .clk       (clk),
        .load_prod (adv2),
        .load_res  (adv_o),
        .cursor    (s1_cy_reg),
        .scale     (scale_y_reg),
        .result    (py)
    );

    assign points.valid      = o_v_reg;
    assign points.point_kind = o_kind_reg;
    assign points.point_x    = px;
    assign points.point_y    = py;

    `VTGD_ASSERT_IMP(a_empty_out_ready, !o_v_reg, items.ready)
    `VTGD_ASSERT_NXT(a_s2_hold, s2_v_reg && !adv_o, s2_v_reg && $stable(s2_kind_reg))

endmodule

`default_nettype wire

// File: tb/vtgd_point_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtgd_point_checker
// Watches the word, point and config channels of the geometry decoder. It
// tracks cursor, command and scale state from accepted items and config
// writes, queues the point each word should produce, and compares every
// accepted point field by field with the oldest queued one.
// ----------------------------------------------------------------------------

module vtgd_point_checker #(
    parameter int SCALE_FRACTION_BITS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    vtgd_word_if      items,
    vtgd_point_if     points,
    vtgd_cfg_if       cfg,
    output int        failures,
    output int        points_pending,
    output int        words_seen,
    output int        points_seen
);
    import vtgd_pkg::*;

    typedef struct packed {
        kind_t              kind;
        logic [POINT_W-1:0] x;
        logic [POINT_W-1:0] y;
    } point_t;

    point_t              expected_points[$];
    logic [WORD_W-1:0]   scale_x;
    logic [WORD_W-1:0]   scale_y;
    logic [WORD_W-1:0]   cursor_x;
    logic [WORD_W-1:0]   cursor_y;
    logic [WORD_W-1:0]   held_x;
    logic [COUNT_W-1:0]  pairs_left;
    kind_t               pair_kind;
    logic                awaiting_y;
    int                  mismatches;
    int                  word_count;
    int                  point_count;

    function automatic logic [WORD_W-1:0] zigzag_delta(input logic [WORD_W-1:0] w);
        return {1'b0, w[WORD_W-1:1]} ^ {WORD_W{w[0]}};
    endfunction

    // signed cursor times unsigned Q scale, realigned to 16 fraction bits
    // and saturated to the 48-bit point range
    function automatic logic [POINT_W-1:0] scaled(input logic [WORD_W-1:0] c,
                                                   input logic [WORD_W-1:0] s);
        logic               neg;
        logic [63:0]        mag;
        logic [63:0]        lim;
        logic [63:0]        q;
        logic [63:0]        low_mask;
        logic [POINT_W-1:0] q48;
        int                 up;
        int                 down;
        neg  = c[WORD_W-1];
        mag  = {32'd0, neg ? (~c + 32'd1) : c};
        mag  = mag * {32'd0, s};
        up   = (SCALE_FRACTION_BITS < 16) ? 16 - SCALE_FRACTION_BITS : 0;
        down = (SCALE_FRACTION_BITS > 16) ? SCALE_FRACTION_BITS - 16 : 0;
        lim  = neg ? 64'h0000_8000_0000_0000 : 64'h0000_7FFF_FFFF_FFFF;
        if (down > 0)
        begin
            low_mask = (64'd1 << down) - 64'd1;
            q = (mag >> down) + (((mag & low_mask) + (neg ? low_mask : 64'd0)) >> down);
        end
        else if (up > 0)
        begin
            q = (mag > (lim >> up)) ? lim : (mag << up);
        end
        else
        begin
            q = mag;
        end
        if (q > lim)
            q = lim;
        q48 = q[POINT_W-1:0];
        return neg ? (~q48 + 1'b1) : q48;
    endfunction

    task automatic clear_cursor();
        cursor_x   = '0;
        cursor_y   = '0;
        pairs_left = '0;
        held_x     = '0;
        awaiting_y = 1'b0;
        pair_kind  = KIND_MOVE;
    endtask

    task automatic decode_word(input logic [WORD_W-1:0] w, input logic last);
        logic  emit;
        kind_t k;
        emit = 1'b0;
        k    = KIND_MOVE;
        if (pairs_left == '0)
        begin
            if ((w[2:0] == CMD_ID_MOVE || w[2:0] == CMD_ID_LINE) && w[WORD_W-1:3] != '0)
            begin
                pair_kind  = (w[2:0] == CMD_ID_MOVE) ? KIND_MOVE : KIND_LINE;
                pairs_left = w[WORD_W-1:3];
                awaiting_y = 1'b0;
            end
            else if (w[2:0] == CMD_ID_CLOSE)
            begin
                k    = KIND_CLOSE;
                emit = 1'b1;
            end
        end
        else if (!awaiting_y)
        begin
            held_x     = w;
            awaiting_y = 1'b1;
        end
        else
        begin
            cursor_x   = cursor_x + zigzag_delta(held_x);
            cursor_y   = cursor_y + zigzag_delta(w);
            awaiting_y = 1'b0;
            held_x     = '0;
            k          = pair_kind;
            emit       = 1'b1;
            pairs_left = pairs_left - 1'b1;
        end
        if (last && (pairs_left != '0 || awaiting_y))
        begin
            k    = KIND_TRUNC;
            emit = 1'b1;
        end
        if (emit)
            expected_points.push_back('{kind: k,
                                        x: scaled(cursor_x, scale_x),
                                        y: scaled(cursor_y, scale_y)});
        if (last)
            clear_cursor();
    endtask

    task automatic report_mismatch(input string field, input logic [POINT_W-1:0] got,
                                   input logic [POINT_W-1:0] want);
        $display("%0t: point %0d %s mismatch: got %h, expected %h",
                 $time, point_count, field, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        point_t exp_point;
        if (!rst_n)
        begin
            scale_x     = SCALE_RESET;
            scale_y     = SCALE_RESET;
            clear_cursor();
            expected_points.delete();
            mismatches  = 0;
            word_count  = 0;
            point_count = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_SCALE_X)
                    scale_x = cfg.data;
                else if (cfg.index == CFG_SCALE_Y)
                    scale_y = cfg.data;
            end
            if (points.valid && points.ready)
            begin
                if (expected_points.size() == 0)
                begin
                    report_mismatch("unexpected, kind", POINT_W'(points.point_kind), '0);
                end
                else
                begin
                    exp_point = expected_points.pop_front();
                    if (points.point_kind !== exp_point.kind)
                        report_mismatch("kind", POINT_W'(points.point_kind),
                                        POINT_W'(exp_point.kind));
                    if (points.point_x !== exp_point.x)
                        report_mismatch("x", points.point_x, exp_point.x);
                    if (points.point_y !== exp_point.y)
                        report_mismatch("y", points.point_y, exp_point.y);
                end
                point_count++;
            end
            if (items.valid && items.ready)
            begin
                decode_word(items.geometry_word, items.last_word);
                word_count++;
            end
        end
        failures       <= mismatches;
        points_pending <= expected_points.size();
        words_seen     <= word_count;
        points_seen    <= point_count;
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression for the vector tile geometry decoder. A directed feature set
// covers field extremes, all command ids, zero counts, close with count bits,
// and truncation on a held x word, on pending pairs and on a command word.
// Random features follow under several scale settings, mostly well formed,
// some cut short or huge-count, plus noise. Bursty sender, patterned stalls.
// ----------------------------------------------------------------------------

module tb;
    import vtgd_pkg::*;

    localparam int FRAC            = 16;
    localparam int WORDS_PER_PHASE = 270;
    localparam int NUM_PHASES      = 6;
    localparam int DRAIN_PAD       = 8;
    localparam int STUCK_LIMIT     = 5000;

    localparam logic [2:0] UNKNOWN_IDS [5] = '{3'd0, 3'd3, 3'd4, 3'd5, 3'd6};

    localparam logic [WORD_W-1:0] PHASE_SCALE_X [NUM_PHASES] =
        '{SCALE_RESET, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 32'h0, SCALE_RESET};
    localparam logic [WORD_W-1:0] PHASE_SCALE_Y [NUM_PHASES] =
        '{SCALE_RESET, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};

    typedef struct packed {
        logic              last;
        logic [WORD_W-1:0] word;
    } geo_item_t;

    logic clk;
    logic rst_n;

    vtgd_word_if  items();
    vtgd_point_if points();
    vtgd_cfg_if   cfg();

    int        mismatch_total;
    int        points_pending;
    int        words_seen;
    int        points_seen;
    int        stuck_cycles;
    int        burst_left;
    geo_item_t geo_items[$];

    vector_tile_geometry_decoder_unit #(
        .SCALE_FRACTION_BITS(FRAC)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .items  (items),
        .points (points),
        .cfg    (cfg)
    );

    vtgd_point_checker #(
        .SCALE_FRACTION_BITS(FRAC)
    ) point_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .items          (items),
        .points         (points),
        .cfg            (cfg),
        .failures       (mismatch_total),
        .points_pending (points_pending),
        .words_seen     (words_seen),
        .points_seen    (points_seen)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic logic [WORD_W-1:0] command_word(input logic [COUNT_W-1:0] count,
                                                       input logic [2:0] id);
        return {count, id};
    endfunction

    function automatic logic [WORD_W-1:0] param_word();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return WORD_W'($urandom_range(0, 511));
            5, 6:          return $urandom;
            7:             return '0;
            8:             return 32'hFFFF_FFFF;
            default:       return 32'hFFFF_FFFE;
        endcase
    endfunction

    function automatic void add_word(input logic [WORD_W-1:0] w, input logic last);
        geo_items.push_back('{last: last, word: w});
    endfunction

    function automatic void add_pairs(input int count);
        for (int i = 0; i < 2 * count; i++)
            add_word(param_word(), 1'b0);
    endfunction

    task automatic send_word(input logic [WORD_W-1:0] w, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                items.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        items.valid         <= 1'b1;
        items.geometry_word <= w;
        items.last_word     <= last;
        do @(posedge clk); while (!items.ready);
    endtask

    task automatic send_feature(inout int sent);
        foreach (geo_items[i])
            send_word(geo_items[i].word, geo_items[i].last);
        sent += geo_items.size();
        geo_items.delete();
    endtask

    task automatic drain_points(input bit pad);
        items.valid <= 1'b0;
        do @(posedge clk); while (points_pending != 0);
        if (pad)
            repeat (DRAIN_PAD) @(posedge clk);
    endtask

    task automatic write_scales(input logic [WORD_W-1:0] sx, input logic [WORD_W-1:0] sy);
        cfg.valid <= 1'b1;
        cfg.index <= CFG_SCALE_X;
        cfg.data  <= sx;
        do @(posedge clk); while (!cfg.ready);
        cfg.index <= CFG_SCALE_Y;
        cfg.data  <= sy;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    task automatic build_random_feature();
        int r;
        int count;
        int cut;
        for (int c = $urandom_range(1, 6); c > 0; c--)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
            begin
                count = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40)
                                                     : $urandom_range(1, 4);
                add_word(command_word(COUNT_W'(count), (r < 30) ? CMD_ID_MOVE : CMD_ID_LINE),
                         1'b0);
                add_pairs(count);
            end
            else if (r < 88)
            begin
                add_word(command_word('0, CMD_ID_CLOSE), 1'b0);
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0: add_word(command_word(COUNT_W'($urandom),
                                             UNKNOWN_IDS[$urandom_range(0, 4)]), 1'b0);
                    1: add_word(command_word('0, $urandom_range(0, 1) ? CMD_ID_MOVE
                                                                      : CMD_ID_LINE), 1'b0);
                    default: add_word(command_word(COUNT_W'($urandom), CMD_ID_CLOSE), 1'b0);
                endcase
            end
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            // huge count: the feature ends with pairs pending unless the random count is tiny
            add_word(command_word(COUNT_W'($urandom) | COUNT_W'(1),
                                  $urandom_range(0, 1) ? CMD_ID_MOVE : CMD_ID_LINE), 1'b0);
            for (int i = $urandom_range(0, 7); i > 0; i--)
                add_word(param_word(), 1'b0);
        end
        else if (r < 16)
        begin
            cut = $urandom_range(0, geo_items.size() - 1);
            while (geo_items.size() > cut + 1)
                void'(geo_items.pop_back());
        end
        geo_items[geo_items.size() - 1].last = 1'b1;
    endtask

    task automatic build_noise();
        for (int i = $urandom_range(1, 6); i > 0; i--)
            add_word($urandom, $urandom_range(0, 7) == 0);
        geo_items[geo_items.size() - 1].last = 1'b1;
    endtask

    task automatic build_directed();
        // extreme deltas: +2^31-1 and -2^31
        add_word(command_word(COUNT_W'(1), CMD_ID_MOVE), 1'b0);
        add_word(32'hFFFF_FFFE, 1'b0);
        add_word(32'hFFFF_FFFF, 1'b0);
        // line pairs with deltas -1, 0, -2^31 and +2^31-1 from the extreme cursor
        add_word(command_word(COUNT_W'(2), CMD_ID_LINE), 1'b0);
        add_word(32'h0000_0001, 1'b0);
        add_word(32'h0000_0000, 1'b0);
        add_word(32'hFFFF_FFFF, 1'b0);
        add_word(32'hFFFF_FFFE, 1'b0);
        add_word(command_word('1, CMD_ID_CLOSE), 1'b0);
        add_word(command_word('1, UNKNOWN_IDS[0]), 1'b0);
        add_word(command_word(COUNT_W'(1), UNKNOWN_IDS[1]), 1'b0);
        add_word(command_word(COUNT_W'(32'h0AAA_AAAB), UNKNOWN_IDS[2]), 1'b0);
        add_word(command_word('0, UNKNOWN_IDS[3]), 1'b0);
        add_word(command_word(COUNT_W'(1), UNKNOWN_IDS[4]), 1'b0);
        add_word(command_word('0, CMD_ID_MOVE), 1'b0);
        add_word(command_word('0, CMD_ID_LINE), 1'b0);
        add_word(command_word('0, CMD_ID_CLOSE), 1'b1);
        // end on a held x word
        add_word(command_word(COUNT_W'(1), CMD_ID_MOVE), 1'b0);
        add_word(32'h0000_0010, 1'b1);
        // maximum count, end with pairs still pending
        add_word(command_word('1, CMD_ID_MOVE), 1'b0);
        add_word(32'h0000_0002, 1'b0);
        add_word(32'h0000_0003, 1'b0);
        add_word(32'h0000_0004, 1'b1);
        // end on the command word itself
        add_word(command_word(COUNT_W'(1), CMD_ID_LINE), 1'b1);
    endtask

    // receiver: modes of random length, each with its own ready pattern
    initial
    begin
        int mode;
        int mode_left;
        int tick;
        mode      = 0;
        mode_left = 0;
        tick      = 0;
        points.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 200);
            end
            mode_left--;
            tick++;
            case (mode)
                0:       points.ready <= 1'b1;
                1:       points.ready <= 1'($urandom_range(0, 1));
                2:       points.ready <= ($urandom_range(0, 3) == 0);
                default: points.ready <= ((tick % 7) < 4);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (items.valid && items.ready) || (points.valid && points.ready)
            || (cfg.valid && cfg.ready))
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("no handshake for %0d cycles", STUCK_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial
    begin
        int phase_words;
        rst_n               <= 1'b0;
        items.valid         <= 1'b0;
        items.geometry_word <= '0;
        items.last_word     <= 1'b0;
        cfg.valid           <= 1'b0;
        cfg.index           <= CFG_SCALE_X;
        cfg.data            <= '0;
        burst_left          = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        phase_words = 0;
        build_directed();
        send_feature(phase_words);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase > 0)
            begin
                drain_points(1'b1);
                if (phase == 4)
                    write_scales($urandom, $urandom);
                else
                    write_scales(PHASE_SCALE_X[phase], PHASE_SCALE_Y[phase]);
            end
            phase_words = 0;
            while (phase_words < WORDS_PER_PHASE)
            begin
                if ($urandom_range(0, 19) == 0)
                    build_noise();
                else
                    build_random_feature();
                send_feature(phase_words);
                if ($urandom_range(0, 29) == 0)
                    drain_points(1'b0);
            end
        end

        drain_points(1'b1);
        $display("%0d geometry words over %0d scale settings, %0d points compared",
                 words_seen, NUM_PHASES, points_seen);
        $display("features: directed corners, random, cut short, huge counts, noise");
        if (mismatch_total == 0 && points_pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
